/* src/jsu_pkg.sv */
// Shared types and constants for the JSON string unescape block.
package jsu_pkg;

  localparam int BYTE_W      = 8;
  localparam int MAX_RESULTS = 5;
  localparam int MAX_DATA    = 4;
  localparam int CNT_W       = $clog2(MAX_RESULTS + 1);

  // Top six bits of a UTF-16 unit that mark high and low surrogates
  localparam logic [5:0]  SURR_HI_TAG = 6'b110110;
  localparam logic [5:0]  SURR_LO_TAG = 6'b110111;
  localparam logic [20:0] SUPP_BASE   = 21'h10000;

  // UTF-8 length limits
  localparam logic [20:0] UTF8_MAX1 = 21'h00007F;
  localparam logic [20:0] UTF8_MAX2 = 21'h0007FF;
  localparam logic [20:0] UTF8_MAX3 = 21'h00FFFF;

  // Decoder modes
  typedef enum logic [5:0] {
    MD_PLAIN   = 6'b000001,
    MD_ESC     = 6'b000010,
    MD_HEX1    = 6'b000100,
    MD_WANT_BS = 6'b001000,
    MD_WANT_U  = 6'b010000,
    MD_HEX2    = 6'b100000
  } mode_t;

  // One result item
  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              is_end;
    logic              error;
  } result_t;

endpackage

/* src/json_string_unescape.sv */
// Top level: streaming JSON string unescape with UTF-8 output.
// An accepted request's results wait in the result group, then the output register.
// Throughput: one input byte per cycle while out_stall is low and each item gives
// at most one result; a larger item holds the input while the group drains out.
// Reset (rst_n low, synchronous) returns the decoder to plain text mode and
// empties the result group and output register.
module json_string_unescape
  import jsu_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [BYTE_W-1:0] in_byte,
  input  logic              in_last,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [BYTE_W-1:0] out_byte,
  output logic              out_is_end,
  output logic              out_error
);

  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_B      = 8'h62;
  localparam logic [7:0] CH_F      = 8'h66;
  localparam logic [7:0] CH_N      = 8'h6E;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_U      = 8'h75;

  // Hex digit to {ok, value}
  function automatic logic [4:0] hex_nib(input logic [7:0] c);
    logic [7:0] d;
    begin
      d = 8'h00;
      hex_nib = 5'b0_0000;
      if (c inside {[8'h30:8'h39]}) begin
        d = c - 8'h30;
        hex_nib = {1'b1, d[3:0]};
      end else if (c inside {[8'h61:8'h66]}) begin
        d = c - 8'h57;
        hex_nib = {1'b1, d[3:0]};
      end else if (c inside {[8'h41:8'h46]}) begin
        d = c - 8'h37;
        hex_nib = {1'b1, d[3:0]};
      end
    end
  endfunction

  // Decoder state
  mode_t       mode_r, mode_nxt;
  logic [1:0]  hcnt_r, hcnt_nxt;
  logic [15:0] acc_r, acc_nxt;
  logic [9:0]  hs_r, hs_nxt;
  logic        err_r, err_nxt;

  // Result group and output register
  result_t           grp_r [MAX_RESULTS];
  result_t           grp_nxt [MAX_RESULTS];
  logic [CNT_W-1:0]  grp_cnt_r, grp_cnt_nxt;
  result_t           outq_r, outq_nxt;
  logic              out_valid_r, out_valid_nxt;

  // Decode results
  result_t          slot [MAX_RESULTS];
  logic [CNT_W-1:0] res_n;
  logic [4:0]       nib;
  logic [15:0]      acc_sh;
  logic             lit_en;
  logic [7:0]       lit_byte;
  logic             emit_en;
  logic [20:0]      emit_cp;
  logic [7:0]       dat [MAX_DATA];
  logic [CNT_W-1:0] dat_n;
  logic             end_err;

  logic in_acc;
  logic move;

  // Hand off the group head when the output register frees up
  assign move     = (grp_cnt_r != '0) && (!out_valid_r || !out_stall);
  assign in_stall = !((grp_cnt_r == '0) ||
                      ((grp_cnt_r == CNT_W'(1)) && move));
  assign in_acc   = in_valid && !in_stall;

  assign nib    = hex_nib(in_byte);
  assign acc_sh = {acc_r[11:0], nib[3:0]};

  // Advance the decoder for one byte
  always_comb begin
    mode_nxt = mode_r;
    hcnt_nxt = hcnt_r;
    acc_nxt  = acc_r;
    hs_nxt   = hs_r;
    err_nxt  = err_r;
    lit_en   = 1'b0;
    lit_byte = in_byte;
    emit_en  = 1'b0;
    emit_cp  = '0;
    if (!err_r) begin
      case (mode_r)
        MD_ESC: begin
          mode_nxt = MD_PLAIN;
          case (in_byte)
            CH_B: begin
              lit_en = 1'b1; lit_byte = 8'h08;
            end
            CH_F: begin
              lit_en = 1'b1; lit_byte = 8'h0C;
            end
            CH_N: begin
              lit_en = 1'b1; lit_byte = 8'h0A;
            end
            CH_R: begin
              lit_en = 1'b1; lit_byte = 8'h0D;
            end
            CH_T: begin
              lit_en = 1'b1; lit_byte = 8'h09;
            end
            CH_BSLASH, CH_QUOTE, CH_SLASH: begin
              lit_en = 1'b1;
            end
            CH_U: begin
              mode_nxt = MD_HEX1;
              hcnt_nxt = 2'd0;
              acc_nxt  = 16'h0000;
            end
            default: begin
              err_nxt  = 1'b1;
              mode_nxt = MD_ESC;
            end
          endcase
        end
        MD_HEX1: begin
          if (!nib[4]) begin
            err_nxt = 1'b1;
          end else begin
            acc_nxt = acc_sh;
            if (hcnt_r == 2'd3) begin
              hcnt_nxt = 2'd0;
              if (acc_sh[15:10] == SURR_HI_TAG) begin
                hs_nxt   = acc_sh[9:0];
                mode_nxt = MD_WANT_BS;
              end else if (acc_sh[15:10] == SURR_LO_TAG) begin
                err_nxt = 1'b1;
              end else begin
                emit_en  = 1'b1;
                emit_cp  = {5'd0, acc_sh};
                mode_nxt = MD_PLAIN;
              end
            end else begin
              hcnt_nxt = hcnt_r + 2'd1;
            end
          end
        end
        MD_WANT_BS: begin
          if (in_byte == CH_BSLASH) mode_nxt = MD_WANT_U;
          else err_nxt = 1'b1;
        end
        MD_WANT_U: begin
          if (in_byte == CH_U) begin
            mode_nxt = MD_HEX2;
            hcnt_nxt = 2'd0;
            acc_nxt  = 16'h0000;
          end else begin
            err_nxt = 1'b1;
          end
        end
        MD_HEX2: begin
          if (!nib[4]) begin
            err_nxt = 1'b1;
          end else begin
            acc_nxt = acc_sh;
            if (hcnt_r == 2'd3) begin
              hcnt_nxt = 2'd0;
              if (acc_sh[15:10] != SURR_LO_TAG) begin
                err_nxt = 1'b1;
              end else begin
                emit_en  = 1'b1;
                emit_cp  = SUPP_BASE + {1'b0, hs_r, acc_sh[9:0]};
                mode_nxt = MD_PLAIN;
              end
            end else begin
              hcnt_nxt = hcnt_r + 2'd1;
            end
          end
        end
        default: begin
          if (in_byte == CH_BSLASH) mode_nxt = MD_ESC;
          else lit_en = 1'b1;
        end
      endcase
    end
    // Close the string: report status and return to idle
    end_err = err_nxt || (mode_nxt != MD_PLAIN);
    if (in_last) begin
      mode_nxt = MD_PLAIN;
      hcnt_nxt = 2'd0;
      acc_nxt  = 16'h0000;
      hs_nxt   = 10'd0;
      err_nxt  = 1'b0;
    end
  end

  // Encode literal or code point into data bytes
  always_comb begin
    for (int i = 0; i < MAX_DATA; i++) dat[i] = 8'h00;
    dat_n = '0;
    if (lit_en) begin
      dat[0] = lit_byte;
      dat_n  = CNT_W'(1);
    end else if (emit_en) begin
      if (emit_cp <= UTF8_MAX1) begin
        dat[0] = emit_cp[7:0];
        dat_n  = CNT_W'(1);
      end else if (emit_cp <= UTF8_MAX2) begin
        dat[0] = {3'b110, emit_cp[10:6]};
        dat[1] = {2'b10, emit_cp[5:0]};
        dat_n  = CNT_W'(2);
      end else if (emit_cp <= UTF8_MAX3) begin
        dat[0] = {4'b1110, emit_cp[15:12]};
        dat[1] = {2'b10, emit_cp[11:6]};
        dat[2] = {2'b10, emit_cp[5:0]};
        dat_n  = CNT_W'(3);
      end else begin
        dat[0] = {5'b11110, emit_cp[20:18]};
        dat[1] = {2'b10, emit_cp[17:12]};
        dat[2] = {2'b10, emit_cp[11:6]};
        dat[3] = {2'b10, emit_cp[5:0]};
        dat_n  = CNT_W'(4);
      end
    end
  end

  // Build the result group, end result after the data bytes
  always_comb begin
    for (int i = 0; i < MAX_RESULTS; i++) slot[i] = '0;
    for (int i = 0; i < MAX_DATA; i++) slot[i].data = dat[i];
    for (int i = 0; i < MAX_RESULTS; i++) begin
      if (in_last && (CNT_W'(i) == dat_n)) begin
        slot[i].data   = 8'h00;
        slot[i].is_end = 1'b1;
        slot[i].error  = end_err;
      end
    end
    res_n = dat_n + CNT_W'(in_last);
  end

  // Drain the group one result a cycle while the output is not stalled; load a new group on acceptance
  always_comb begin
    for (int i = 0; i < MAX_RESULTS; i++) grp_nxt[i] = grp_r[i];
    grp_cnt_nxt   = grp_cnt_r;
    outq_nxt      = outq_r;
    out_valid_nxt = out_valid_r;
    if (move) begin
      outq_nxt      = grp_r[0];
      out_valid_nxt = 1'b1;
      for (int i = 0; i < MAX_RESULTS - 1; i++) grp_nxt[i] = grp_r[i+1];
      grp_nxt[MAX_RESULTS-1] = '0;
      grp_cnt_nxt = grp_cnt_r - CNT_W'(1);
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
    if (in_acc) begin
      for (int i = 0; i < MAX_RESULTS; i++) grp_nxt[i] = slot[i];
      grp_cnt_nxt = res_n;
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= MD_PLAIN;
      hcnt_r      <= 2'd0;
      acc_r       <= 16'h0000;
      hs_r        <= 10'd0;
      err_r       <= 1'b0;
      grp_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_acc) begin
        mode_r <= mode_nxt;
        hcnt_r <= hcnt_nxt;
        acc_r  <= acc_nxt;
        hs_r   <= hs_nxt;
        err_r  <= err_nxt;
      end
      grp_cnt_r   <= grp_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    for (int i = 0; i < MAX_RESULTS; i++) grp_r[i] <= grp_nxt[i];
    outq_r <= outq_nxt;
  end

  assign out_valid  = out_valid_r;
  assign out_byte   = outq_r.data;
  assign out_is_end = outq_r.is_end;
  assign out_error  = outq_r.error;

endmodule

/* src/jsu_checker.sv */
// Port-level assertion checker for the JSON string unescape block, with its bind.
module jsu_checker
  import jsu_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_stall,
  input logic [BYTE_W-1:0] in_byte,
  input logic              in_last,
  input logic              out_valid,
  input logic              out_stall,
  input logic [BYTE_W-1:0] out_byte,
  input logic              out_is_end,
  input logic              out_error
);

  // Hold a stalled request
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |=> in_valid && $stable(in_byte) && $stable(in_last))
    else $error("stalled request changed");

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_byte) &&
      $stable(out_is_end) && $stable(out_error))
    else $error("stalled result changed");

  // Error is only reported on the end result
  a_err_on_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_error |-> out_is_end)
    else $error("error flag on a data result");

  // End result carries a zero byte
  a_end_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_is_end |-> out_byte == '0)
    else $error("end result byte not zero");

  // Nothing shows up at the output right after reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind json_string_unescape jsu_checker u_jsu_checker (.*);
